// ----- rtl/lifo_stack_with_search_and_max_top_defines.svh -----
// Assertion macros shared by the stack controller and datapath.
`ifndef LIFO_STACK_WITH_SEARCH_AND_MAX_TOP_DEFINES_SVH
`define LIFO_STACK_WITH_SEARCH_AND_MAX_TOP_DEFINES_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define LSM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that cons holds in the cycle after ante holds.
`define LSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lsm_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the stack.
`default_nettype none

package lsm_pkg;

  localparam int DEPTH_DEF     = 64;
  localparam int WORD_BITS_DEF = 32;
  localparam int REQ_BITS      = 3;
  localparam int INDEX_BITS    = 6;
  localparam int STATUS_BITS   = 2;
  localparam int FILL_BITS     = 7;

  localparam logic [REQ_BITS-1:0] REQ_PUSH    = 3'd0;
  localparam logic [REQ_BITS-1:0] REQ_POP     = 3'd1;
  localparam logic [REQ_BITS-1:0] REQ_PEEK    = 3'd2;
  localparam logic [REQ_BITS-1:0] REQ_SEARCH  = 3'd3;
  localparam logic [REQ_BITS-1:0] REQ_LARGEST = 3'd4;

  localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [1:0] SEL_ZERO  = 2'd0;
  localparam logic [1:0] SEL_RDATA = 2'd1;
  localparam logic [1:0] SEL_BEST  = 2'd2;

  typedef struct packed {
    logic                   load;
    logic                   push;
    logic                   pop;
    logic                   rd_top;
    logic                   scan_start;
    logic                   scan_next;
    logic                   best_upd;
    logic                   finish;
    logic                   idx_take;
    logic [1:0]             res_sel;
    logic [STATUS_BITS-1:0] res_st;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic match;
    logic last;
  } stat_t;

endpackage

`default_nettype wire

// ----- rtl/lsm_ram.sv -----
// Generic simple dual-port RAM (separate write and read addresses) with one write and one registered read per cycle.
`default_nettype none

module lsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/lsm_datapath.sv -----
// Stack datapath: word store, fill count, scan pointer, running maximum and result words.
`default_nettype none
`include "lifo_stack_with_search_and_max_top_defines.svh"

module lsm_datapath #(
  parameter int DEPTH     = lsm_pkg::DEPTH_DEF,
  parameter int WORD_BITS = lsm_pkg::WORD_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire lsm_pkg::cmd_t                       cmd,
  input  wire logic signed [WORD_BITS-1:0]         data_in,
  output lsm_pkg::stat_t                           stat,
  output logic signed      [WORD_BITS-1:0]         data_out,
  output logic             [lsm_pkg::INDEX_BITS-1:0]  index_out,
  output logic             [lsm_pkg::STATUS_BITS-1:0] status,
  output logic             [lsm_pkg::FILL_BITS-1:0]   fill_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] best;
  logic [WORD_BITS-1:0] best_next;
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] res_word;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic [CW-1:0]        ptr;
  logic [AW-1:0]        raddr;
  logic                 first;

  assign first = (ptr == CW'(1));

  always_comb begin
    count_next = count;
    if (cmd.push) begin
      count_next = count + CW'(1);
    end else if (cmd.pop) begin
      count_next = count - CW'(1);
    end
  end

  always_comb begin
    if (cmd.rd_top) begin
      raddr = AW'(count - CW'(1));
    end else if (cmd.scan_start) begin
      raddr = '0;
    end else begin
      raddr = AW'(ptr);
    end
  end

  assign best_next = (first || ($signed(rdata) > $signed(best))) ? rdata : best;

  always_comb begin
    case (cmd.res_sel)
      lsm_pkg::SEL_RDATA: res_word = rdata;
      lsm_pkg::SEL_BEST:  res_word = best_next;
      default:            res_word = '0;
    endcase
  end

  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);
  assign stat.match = (rdata == word);
  assign stat.last  = (ptr == count);

  lsm_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.push),
    .waddr(AW'(count)),
    .wdata(word),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word <= data_in;
    end
    if (cmd.scan_start) begin
      ptr <= CW'(1);
    end else if (cmd.scan_next) begin
      ptr <= ptr + CW'(1);
    end
    if (cmd.best_upd) begin
      best <= best_next;
    end
    if (cmd.finish) begin
      data_out   <= res_word;
      index_out  <= cmd.idx_take ? lsm_pkg::INDEX_BITS'(ptr - CW'(1)) : '0;
      status     <= cmd.res_st;
      fill_count <= lsm_pkg::FILL_BITS'(count_next);
    end
  end

  `LSM_ASSERT_SAME(a_count_bound, 1'b1, count <= CW'(DEPTH), "Fill count exceeds depth.")
  `LSM_ASSERT_SAME(a_push_room, cmd.push, !stat.full, "Push issued on a full stack.")

endmodule

`default_nettype wire

// ----- rtl/lsm_ctrl.sv -----
// Stack controller: request decoding, scan sequencing and the result strobe.
`default_nettype none
`include "lifo_stack_with_search_and_max_top_defines.svh"

module lsm_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [lsm_pkg::REQ_BITS-1:0]   req_type,
  input  wire lsm_pkg::stat_t                 stat,
  output lsm_pkg::cmd_t                       cmd,
  output logic                                busy,
  output logic                                done
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_SCAN = 2'd3;

  logic [1:0]                     state;
  logic [1:0]                     state_next;
  logic [lsm_pkg::REQ_BITS-1:0]   req;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.res_sel = lsm_pkg::SEL_ZERO;
    cmd.res_st  = lsm_pkg::ST_OK;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (req)
          lsm_pkg::REQ_PUSH: begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
            if (stat.full) begin
              cmd.res_st = lsm_pkg::ST_FULL;
            end else begin
              cmd.push = 1'b1;
            end
          end
          lsm_pkg::REQ_POP, lsm_pkg::REQ_PEEK: begin
            if (stat.empty) begin
              cmd.finish = 1'b1;
              cmd.res_st = lsm_pkg::ST_EMPTY;
              state_next = S_IDLE;
            end else begin
              cmd.rd_top = 1'b1;
              cmd.pop    = (req == lsm_pkg::REQ_POP);
              state_next = S_READ;
            end
          end
          lsm_pkg::REQ_SEARCH, lsm_pkg::REQ_LARGEST: begin
            if (stat.empty) begin
              cmd.finish = 1'b1;
              cmd.res_st = (req == lsm_pkg::REQ_SEARCH) ? lsm_pkg::ST_NOT_FOUND
                                                        : lsm_pkg::ST_EMPTY;
              state_next = S_IDLE;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
          end
          default: begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      S_READ: begin
        cmd.finish  = 1'b1;
        cmd.res_sel = lsm_pkg::SEL_RDATA;
        state_next  = S_IDLE;
      end
      S_SCAN: begin
        if (req == lsm_pkg::REQ_SEARCH) begin
          if (stat.match) begin
            cmd.finish   = 1'b1;
            cmd.idx_take = 1'b1;
            state_next   = S_IDLE;
          end else if (stat.last) begin
            cmd.finish = 1'b1;
            cmd.res_st = lsm_pkg::ST_NOT_FOUND;
            state_next = S_IDLE;
          end else begin
            cmd.scan_next = 1'b1;
          end
        end else begin
          cmd.best_upd = 1'b1;
          if (stat.last) begin
            cmd.finish  = 1'b1;
            cmd.res_sel = lsm_pkg::SEL_BEST;
            state_next  = S_IDLE;
          end else begin
            cmd.scan_next = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= req_type;
    end
  end

  `LSM_ASSERT_SAME(a_done_idle, done, !busy, "Result strobe while a request is in progress.")
  `LSM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "Accepted request did not start.")
  `LSM_ASSERT_NEXT(a_read_done, state == S_READ, done, "Top read did not complete.")

endmodule

`default_nettype wire

// ----- rtl/lifo_stack_with_search_and_max_top.sv -----
// Top level of the LIFO stack with search and largest-word queries.
//
//   Channel   Handshake          Ports
//   request   start, busy        req_type, data_in
//   result    done (one cycle)   data_out, index_out, status, fill_count
//
// A request is taken when start is high and busy is low; its result word follows on done.
// Push, unknown requests and requests on an empty stack finish in EXEC; pop and peek
// pass through READ. Search and largest read the store one entry a cycle through its
// read port in SCAN, reading at most as many entries as the fill count.
// Synchronous reset empties the stack at once; no clearing pass is needed.
// busy stays high until the result is presented; the receiver cannot stall.
`default_nettype none

module lifo_stack_with_search_and_max_top #(
  parameter int DEPTH     = lsm_pkg::DEPTH_DEF,
  parameter int WORD_BITS = lsm_pkg::WORD_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic        [lsm_pkg::REQ_BITS-1:0]   req_type,
  input  wire logic signed [WORD_BITS-1:0]           data_in,
  output logic                                       done,
  output logic signed      [WORD_BITS-1:0]           data_out,
  output logic             [lsm_pkg::INDEX_BITS-1:0]  index_out,
  output logic             [lsm_pkg::STATUS_BITS-1:0] status,
  output logic             [lsm_pkg::FILL_BITS-1:0]   fill_count
);

  lsm_pkg::cmd_t  cmd;
  lsm_pkg::stat_t stat;

  lsm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .req_type(req_type),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy),
    .done    (done)
  );

  lsm_datapath #(
    .DEPTH    (DEPTH),
    .WORD_BITS(WORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .data_in   (data_in),
    .stat      (stat),
    .data_out  (data_out),
    .index_out (index_out),
    .status    (status),
    .fill_count(fill_count)
  );

endmodule

`default_nettype wire

// ----- verif/lifo_stack_with_search_and_max_reply_check.sv -----
// Reply checker for the stack: predicts each result word from the requests and compares it.
module lifo_stack_with_search_and_max_reply_check #(
  parameter int DEPTH     = lsm_pkg::DEPTH_DEF,
  parameter int WORD_BITS = lsm_pkg::WORD_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  input  logic                                      busy,
  input  logic        [lsm_pkg::REQ_BITS-1:0]       req_type,
  input  logic signed [WORD_BITS-1:0]               data_in,
  input  logic                                      done,
  input  logic signed [WORD_BITS-1:0]               data_out,
  input  logic        [lsm_pkg::INDEX_BITS-1:0]     index_out,
  input  logic        [lsm_pkg::STATUS_BITS-1:0]    status,
  input  logic        [lsm_pkg::FILL_BITS-1:0]      fill_count,
  output int                                        error_count,
  output int                                        pending,
  output int                                        checked,
  output int                                        full_seen,
  output int                                        empty_seen,
  output int                                        miss_seen
);
  import lsm_pkg::*;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] word;
    logic [INDEX_BITS-1:0]       index;
    logic [STATUS_BITS-1:0]      status;
    logic [FILL_BITS-1:0]        fill;
  } reply_t;

  logic signed [WORD_BITS-1:0] held [DEPTH];
  int held_count = 0;
  reply_t awaited_replies [$];

  function automatic reply_t apply_request(input logic [REQ_BITS-1:0] req,
                                           input logic signed [WORD_BITS-1:0] word);
    reply_t r;
    logic signed [WORD_BITS-1:0] best;
    r = '0;
    case (req)
      REQ_PUSH: begin
        if (held_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          held[held_count] = word;
          held_count++;
        end
      end
      REQ_POP: begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          held_count--;
          r.word = held[held_count];
        end
      end
      REQ_PEEK: begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.word = held[held_count - 1];
        end
      end
      REQ_SEARCH: begin
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < held_count && r.status != ST_OK; i++) begin
          if (held[i] == word) begin
            r.index  = INDEX_BITS'(i);
            r.status = ST_OK;
          end
        end
      end
      REQ_LARGEST: begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          best = held[0];
          for (int i = 1; i < held_count; i++) begin
            if (held[i] > best) best = held[i];
          end
          r.word = best;
        end
      end
      default: begin
      end
    endcase
    r.fill = FILL_BITS'(held_count);
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    int fails;
    fails = 0;
    if (rst) begin
      held_count = 0;
      awaited_replies.delete();
      error_count <= 0;
      pending     <= 0;
      checked     <= 0;
      full_seen   <= 0;
      empty_seen  <= 0;
      miss_seen   <= 0;
    end else begin
      if (done) begin
        if (awaited_replies.size() == 0) begin
          $error("result word arrived with no request outstanding");
          fails++;
        end else begin
          want = awaited_replies.pop_front();
          if (data_out !== want.word) begin
            $error("data_out: expected %0d, got %0d", want.word, data_out);
            fails++;
          end
          if (index_out !== want.index) begin
            $error("index_out: expected %0d, got %0d", want.index, index_out);
            fails++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            fails++;
          end
          if (fill_count !== want.fill) begin
            $error("fill_count: expected %0d, got %0d", want.fill, fill_count);
            fails++;
          end
          checked    <= checked + 1;
          full_seen  <= full_seen + int'(want.status == ST_FULL);
          empty_seen <= empty_seen + int'(want.status == ST_EMPTY);
          miss_seen  <= miss_seen + int'(want.status == ST_NOT_FOUND);
        end
      end
      if (start && !busy) begin
        awaited_replies.push_back(apply_request(req_type, data_in));
      end
      error_count <= error_count + fails;
      pending     <= awaited_replies.size();
    end
  end

endmodule

// ----- verif/lifo_stack_with_search_and_max_top_test.sv -----
// Test top for the stack: drives request words, guards against hangs and reports the verdict.
module lifo_stack_with_search_and_max_top_test;
  import lsm_pkg::*;

  localparam int ITEMS        = 1200;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 80;

  logic                        clk      = 1'b0;
  logic                        rst      = 1'b1;
  logic                        start    = 1'b0;
  logic [REQ_BITS-1:0]         req_type = REQ_PUSH;
  logic signed [31:0]          data_in  = '0;
  logic                        busy;
  logic                        done;
  logic signed [31:0]          data_out;
  logic [INDEX_BITS-1:0]       index_out;
  logic [STATUS_BITS-1:0]      status;
  logic [FILL_BITS-1:0]        fill_count;

  int error_count;
  int pending;
  int checked;
  int full_seen;
  int empty_seen;
  int miss_seen;
  int quiet_cycles = 0;
  int sent         = 0;
  int burst_left   = 1;

  always #1 clk = ~clk;

  lifo_stack_with_search_and_max_top uut (.*);

  lifo_stack_with_search_and_max_reply_check reply_check (.*);

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 32'($urandom_range(0, 7)) - 32'sd3;
      4: return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_word(input logic [REQ_BITS-1:0] req, input logic signed [31:0] word);
    int gap;
    req_type <= req;
    data_in  <= word;
    start    <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: gap = $urandom_range(1, 4);
        6, 7: gap = $urandom_range(5, 20);
        8: gap = $urandom_range(21, 80);
        default: gap = 0;
      endcase
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int phase;
    int push_pct;
    int pop_pct;
    logic [REQ_BITS-1:0] req;
    phase = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(REQ_POP, $urandom());
    send_word(REQ_PEEK, $urandom());
    send_word(REQ_LARGEST, $urandom());
    send_word(REQ_SEARCH, 32'sd0);
    for (int k = 1; k <= 3; k++) send_word(REQ_BITS'(REQ_LARGEST + k), $urandom());
    send_word(REQ_PUSH, 32'sh8000_0000);
    send_word(REQ_PUSH, 32'sh7FFF_FFFF);
    send_word(REQ_PUSH, 32'sd0);
    send_word(REQ_PUSH, -32'sd1);
    send_word(REQ_PUSH, 32'sh8000_0000);
    send_word(REQ_PEEK, $urandom());
    send_word(REQ_LARGEST, $urandom());
    send_word(REQ_SEARCH, 32'sh8000_0000);
    send_word(REQ_SEARCH, -32'sd1);
    send_word(REQ_SEARCH, 32'sd12345);
    send_word(REQ_POP, $urandom());
    send_word(REQ_POP, $urandom());
    send_word(REQ_LARGEST, $urandom());
    send_word(REQ_POP, $urandom());
    send_word(REQ_LARGEST, $urandom());
    send_word(REQ_POP, $urandom());
    send_word(REQ_POP, $urandom());
    send_word(REQ_SEARCH, 32'sh7FFF_FFFF);
    settle();

    // Alternate filling, draining and mixed phases so that the stack sweeps full and empty.
    while (sent < ITEMS) begin
      case (phase % 3)
        0: begin
          push_pct = 85;
          pop_pct  = 5;
        end
        1: begin
          push_pct = 10;
          pop_pct  = 75;
        end
        default: begin
          push_pct = 35;
          pop_pct  = 30;
        end
      endcase
      repeat ($urandom_range(100, 160)) begin
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct) begin
          req = REQ_PUSH;
        end else if (r < push_pct + pop_pct) begin
          req = REQ_POP;
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2: req = REQ_PEEK;
            3, 4, 5, 6: req = REQ_SEARCH;
            7, 8: req = REQ_LARGEST;
            default: req = REQ_BITS'(REQ_LARGEST + $urandom_range(1, 3));
          endcase
        end
        send_word(req, pick_word());
      end
      if ($urandom_range(0, 1) != 0) settle();
      phase++;
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d requests and %0d checked results over %0d fill phases.",
             sent, checked, phase);
    $display("Results seen: %0d full-stack drops, %0d empty refusals, %0d unmatched searches.",
             full_seen, empty_seen, miss_seen);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
